// File: src/cau_pkg.sv
package cau_pkg;

   localparam int CAU_DATA_WIDTH = 32;
   localparam int CAU_FRAC_BITS  = 16;
   localparam int FUNC_W         = 3;
   localparam int THR_W          = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd1;

   typedef enum logic [FUNC_W-1:0] {
      FN_ADD  = 3'd0,
      FN_SUB  = 3'd1,
      FN_MUL  = 3'd2,
      FN_DIV  = 3'd3,
      FN_CONJ = 3'd4,
      FN_NEG  = 3'd5,
      FN_CMP  = 3'd6
   } func_type;

   localparam logic CSR_ADDR_THR = 1'b0;

endpackage

// File: src/cau_div_step.sv
module cau_div_step
   import cau_pkg::*;
#(
   parameter int CW = 98,
   parameter int DENW = 64,
   parameter int QW = 34,
   parameter int SH = 33
) (
   input  logic            clock,
   input  logic            en,
   input  logic [CW-1:0]   rem_re_in,
   input  logic [CW-1:0]   rem_im_in,
   input  logic [DENW-1:0] den_in,
   input  logic [QW-1:0]   q_re_in,
   input  logic [QW-1:0]   q_im_in,
   output logic [CW-1:0]   rem_re_out,
   output logic [CW-1:0]   rem_im_out,
   output logic [DENW-1:0] den_out,
   output logic [QW-1:0]   q_re_out,
   output logic [QW-1:0]   q_im_out
);

   logic [CW-1:0]   dsh;
   logic            ge_re, ge_im;
   logic [CW-1:0]   rem_re_in_n, rem_im_in_n;
   logic [QW-1:0]   q_re_in_n, q_im_in_n;
   logic [CW-1:0]   rem_re_ff, rem_im_ff;
   logic [DENW-1:0] den_ff;
   logic [QW-1:0]   q_re_ff, q_im_ff;

   always_comb begin
      dsh   = CW'(den_in) << SH;
      ge_re = rem_re_in >= dsh;
      ge_im = rem_im_in >= dsh;
      rem_re_in_n = ge_re ? rem_re_in - dsh : rem_re_in;
      rem_im_in_n = ge_im ? rem_im_in - dsh : rem_im_in;
      q_re_in_n = q_re_in;
      q_im_in_n = q_im_in;
      q_re_in_n[SH] = ge_re;
      q_im_in_n[SH] = ge_im;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_re_ff <= rem_re_in_n;
         rem_im_ff <= rem_im_in_n;
         den_ff    <= den_in;
         q_re_ff   <= q_re_in_n;
         q_im_ff   <= q_im_in_n;
      end
   end

   assign rem_re_out = rem_re_ff;
   assign rem_im_out = rem_im_ff;
   assign den_out    = den_ff;
   assign q_re_out   = q_re_ff;
   assign q_im_out   = q_im_ff;

endmodule

// File: src/complex_arith_unit.sv
// Pipelined signed fixed-point complex ALU (default Q16.16, 32-bit parts). One transfer
// per cycle in and out: add, subtract, multiply, divide, conjugate, negate and exact
// compare, selected by func. Every code takes the same path, whose length is set by the
// restoring divider, which resolves one quotient bit per stage for both result parts. The
// whole pipeline advances together and holds when the result is not taken. Results
// saturate and raise overflow; a divisor that is zero, or whose two parts both have a
// magnitude below zero_threshold (APB address 0, reset 1), gives zero and raises div_zero.
module complex_arith_unit
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = CAU_DATA_WIDTH,
   parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // func, a_re, a_im, b_re, b_im
   input  logic [((FUNC_W+4*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // res_re, res_im, div_zero, overflow, equal
   output logic [((2*DATA_WIDTH+3+7)/8)*8-1:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DW    = DATA_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int IN_W  = ((FUNC_W+4*DW+7)/8)*8;
   localparam int OUT_W = ((2*DW+3+7)/8)*8;
   localparam int MW    = 2*DW;
   localparam int PW    = 2*DW+2;
   localparam int CW    = 3*DW+2;
   localparam int QW    = DW+2;
   localparam int NSTEP = DW+2;
   localparam int NSTG  = NSTEP+4;

   localparam logic signed [PW-1:0] MAXP = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [PW-1:0] MINP = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic signed [PW-1:0] HALF = PW'(1) << (FB-1);
   localparam logic [QW-1:0] QMAXP = {3'b000, {(DW-1){1'b1}}};
   localparam logic [QW-1:0] QMAXN = {3'b001, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] DMAX  = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] DMIN  = {1'b1, {(DW-1){1'b0}}};

   logic en;
   logic [NSTG-1:0] vld_ff, vld_in;

   logic [THR_W-1:0] thr_ff, thr_in;

   // configuration
   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ADDR_THR)
         thr_in = csr_pwdata[THR_W-1:0];
   end
   assign csr_prdata = (csr_paddr == CSR_ADDR_THR) ? 32'(thr_ff) : 32'd0;
   assign csr_pready = 1'b1;

   assign en         = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
         if (en) vld_ff <= vld_in;
      end
   end

   // stage 1: products and simple codes
   logic [FUNC_W-1:0]      f_in;
   logic signed [DW-1:0]   ar, ai, br, bi;
   logic signed [DW:0]     s_re, s_im;
   logic [DW-1:0]          mag_br, mag_bi;
   logic [DW-1:0]          r1_re_in, r1_im_in;
   logic                   ov1_in, eq1_in, sm1_in;

   logic [FUNC_W-1:0]      f1_ff;
   logic signed [MW-1:0]   prr_ff, pii_ff, pir_ff, pri_ff, pbr_ff, pbi_ff;
   logic [DW-1:0]          r1_re_ff, r1_im_ff;
   logic                   ov1_ff, eq1_ff, sm1_ff;

   assign f_in = req_tdata[FUNC_W-1:0];
   assign ar = req_tdata[FUNC_W +: DW];
   assign ai = req_tdata[FUNC_W+DW +: DW];
   assign br = req_tdata[FUNC_W+2*DW +: DW];
   assign bi = req_tdata[FUNC_W+3*DW +: DW];

   always_comb begin
      s_re   = '0;
      s_im   = '0;
      eq1_in = 1'b0;
      case (f_in)
         FN_ADD: begin
            s_re = (DW+1)'(ar) + (DW+1)'(br);
            s_im = (DW+1)'(ai) + (DW+1)'(bi);
         end
         FN_SUB: begin
            s_re = (DW+1)'(ar) - (DW+1)'(br);
            s_im = (DW+1)'(ai) - (DW+1)'(bi);
         end
         FN_CONJ: begin
            s_re = (DW+1)'(ar);
            s_im = -(DW+1)'(ai);
         end
         FN_NEG: begin
            s_re = -(DW+1)'(ar);
            s_im = -(DW+1)'(ai);
         end
         FN_CMP: eq1_in = (ar == br) && (ai == bi);
         default: ;
      endcase
      ov1_in   = (s_re[DW] != s_re[DW-1]) || (s_im[DW] != s_im[DW-1]);
      r1_re_in = (s_re[DW] != s_re[DW-1]) ? (s_re[DW] ? DMIN : DMAX) : s_re[DW-1:0];
      r1_im_in = (s_im[DW] != s_im[DW-1]) ? (s_im[DW] ? DMIN : DMAX) : s_im[DW-1:0];
      mag_br   = br[DW-1] ? -br : br;
      mag_bi   = bi[DW-1] ? -bi : bi;
      sm1_in   = (mag_br < DW'(thr_ff)) && (mag_bi < DW'(thr_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff    <= f_in;
         prr_ff   <= MW'(ar) * MW'(br);
         pii_ff   <= MW'(ai) * MW'(bi);
         pir_ff   <= MW'(ai) * MW'(br);
         pri_ff   <= MW'(ar) * MW'(bi);
         pbr_ff   <= MW'(br) * MW'(br);
         pbi_ff   <= MW'(bi) * MW'(bi);
         r1_re_ff <= r1_re_in;
         r1_im_ff <= r1_im_in;
         ov1_ff   <= ov1_in;
         eq1_ff   <= eq1_in;
         sm1_ff   <= sm1_in;
      end
   end

   // stage 2: product sums
   logic [FUNC_W-1:0]    f2_ff;
   logic signed [PW-1:0] mre_ff, mim_ff, nre_ff, nim_ff;
   logic [MW-1:0]        den2_ff;
   logic [DW-1:0]        r2_re_ff, r2_im_ff;
   logic                 ov2_ff, eq2_ff, sm2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         f2_ff    <= f1_ff;
         mre_ff   <= PW'(prr_ff) - PW'(pii_ff);
         mim_ff   <= PW'(pir_ff) + PW'(pri_ff);
         nre_ff   <= PW'(prr_ff) + PW'(pii_ff);
         nim_ff   <= PW'(pir_ff) - PW'(pri_ff);
         den2_ff  <= MW'(pbr_ff) + MW'(pbi_ff);
         r2_re_ff <= r1_re_ff;
         r2_im_ff <= r1_im_ff;
         ov2_ff   <= ov1_ff;
         eq2_ff   <= eq1_ff;
         sm2_ff   <= sm1_ff;
      end
   end

   // stage 3: multiply rounding, divide setup
   logic signed [PW-1:0] t_re, t_im;
   logic [PW-1:0]        a_re_n, a_im_n;
   logic [DW-1:0]        r3_re_in, r3_im_in;
   logic                 ov3_in, dz3_in;

   always_comb begin
      t_re   = (mre_ff + HALF) >>> FB;
      t_im   = (mim_ff + HALF) >>> FB;
      a_re_n = nre_ff[PW-1] ? -nre_ff : nre_ff;
      a_im_n = nim_ff[PW-1] ? -nim_ff : nim_ff;
      dz3_in = (f2_ff == FN_DIV) && (sm2_ff || den2_ff == '0);
      r3_re_in = r2_re_ff;
      r3_im_in = r2_im_ff;
      ov3_in   = ov2_ff;
      if (f2_ff == FN_MUL) begin
         ov3_in   = (t_re > MAXP) || (t_re < MINP) || (t_im > MAXP) || (t_im < MINP);
         r3_re_in = (t_re > MAXP) ? DMAX : (t_re < MINP) ? DMIN : t_re[DW-1:0];
         r3_im_in = (t_im > MAXP) ? DMAX : (t_im < MINP) ? DMIN : t_im[DW-1:0];
      end
   end

   logic [FUNC_W-1:0] fp_ff  [NSTEP+1];
   logic [DW-1:0]     rre_ff [NSTEP+1];
   logic [DW-1:0]     rim_ff [NSTEP+1];
   logic              ov_ff  [NSTEP+1];
   logic              eq_ff  [NSTEP+1];
   logic              dz_ff  [NSTEP+1];
   logic              sre_ff [NSTEP+1];
   logic              sim_ff [NSTEP+1];
   logic [CW-1:0]     rem_re [NSTEP+1];
   logic [CW-1:0]     rem_im [NSTEP+1];
   logic [MW-1:0]     den    [NSTEP+1];
   logic [QW-1:0]     q_re   [NSTEP+1];
   logic [QW-1:0]     q_im   [NSTEP+1];
   logic [CW-1:0]     rem_re0_ff, rem_im0_ff;
   logic [MW-1:0]     den0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fp_ff[0]   <= f2_ff;
         rre_ff[0]  <= r3_re_in;
         rim_ff[0]  <= r3_im_in;
         ov_ff[0]   <= ov3_in;
         eq_ff[0]   <= eq2_ff;
         dz_ff[0]   <= dz3_in;
         sre_ff[0]  <= nre_ff[PW-1];
         sim_ff[0]  <= nim_ff[PW-1];
         rem_re0_ff <= CW'(a_re_n) << FB;
         rem_im0_ff <= CW'(a_im_n) << FB;
         den0_ff    <= den2_ff;
      end
   end

   assign rem_re[0] = rem_re0_ff;
   assign rem_im[0] = rem_im0_ff;
   assign den[0]    = den0_ff;
   assign q_re[0]   = '0;
   assign q_im[0]   = '0;

   // divider stages, one quotient bit each
   for (genvar k = 0; k < NSTEP; k++) begin : g_div
      cau_div_step #(
         .CW(CW), .DENW(MW), .QW(QW), .SH(DW+1-k)
      ) u_step (
         .clock(clock),
         .en(en),
         .rem_re_in(rem_re[k]),
         .rem_im_in(rem_im[k]),
         .den_in(den[k]),
         .q_re_in(q_re[k]),
         .q_im_in(q_im[k]),
         .rem_re_out(rem_re[k+1]),
         .rem_im_out(rem_im[k+1]),
         .den_out(den[k+1]),
         .q_re_out(q_re[k+1]),
         .q_im_out(q_im[k+1])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            fp_ff[k+1]  <= fp_ff[k];
            rre_ff[k+1] <= rre_ff[k];
            rim_ff[k+1] <= rim_ff[k];
            ov_ff[k+1]  <= ov_ff[k];
            eq_ff[k+1]  <= eq_ff[k];
            dz_ff[k+1]  <= dz_ff[k];
            sre_ff[k+1] <= sre_ff[k];
            sim_ff[k+1] <= sim_ff[k];
         end
      end
   end

   // output stage: quotient sign and saturation
   logic [DW-1:0] o_re_in, o_im_in;
   logic          o_ov_in, o_dz_in;
   logic          ovq_re, ovq_im;
   logic [DW-1:0] o_re_ff, o_im_ff;
   logic          o_ov_ff, o_dz_ff, o_eq_ff;

   always_comb begin
      ovq_re  = sre_ff[NSTEP] ? (q_re[NSTEP] > QMAXN) : (q_re[NSTEP] > QMAXP);
      ovq_im  = sim_ff[NSTEP] ? (q_im[NSTEP] > QMAXN) : (q_im[NSTEP] > QMAXP);
      o_re_in = rre_ff[NSTEP];
      o_im_in = rim_ff[NSTEP];
      o_ov_in = ov_ff[NSTEP];
      o_dz_in = 1'b0;
      if (fp_ff[NSTEP] == FN_DIV) begin
         if (dz_ff[NSTEP]) begin
            o_re_in = '0;
            o_im_in = '0;
            o_ov_in = 1'b0;
            o_dz_in = 1'b1;
         end else begin
            o_ov_in = ovq_re || ovq_im;
            if (ovq_re) o_re_in = sre_ff[NSTEP] ? DMIN : DMAX;
            else o_re_in = sre_ff[NSTEP] ? -q_re[NSTEP][DW-1:0] : q_re[NSTEP][DW-1:0];
            if (ovq_im) o_im_in = sim_ff[NSTEP] ? DMIN : DMAX;
            else o_im_in = sim_ff[NSTEP] ? -q_im[NSTEP][DW-1:0] : q_im[NSTEP][DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_re_ff <= o_re_in;
         o_im_ff <= o_im_in;
         o_ov_ff <= o_ov_in;
         o_dz_ff <= o_dz_in;
         o_eq_ff <= eq_ff[NSTEP];
      end
   end

   assign rsp_tdata = OUT_W'({o_eq_ff, o_ov_ff, o_dz_ff, o_im_ff, o_re_ff});

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import cau_pkg::*;

   localparam int DW = CAU_DATA_WIDTH;
   localparam int FB = CAU_FRAC_BITS;
   localparam int REQ_W = ((FUNC_W+4*DW+7)/8)*8;
   localparam int RSP_W = ((2*DW+3+7)/8)*8;
   localparam int LATENCY = DW+6;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [DW-1:0] res_re;
      logic [DW-1:0] res_im;
      logic          div_zero;
      logic          overflow;
      logic          equal;
   } alu_result;

   // saturating fixed-point complex arithmetic for expected results
   function automatic logic [DW-1:0] clamp_part(input logic signed [159:0] v, ref logic ov);
      logic signed [159:0] maxv;
      logic signed [159:0] minv;
      maxv = (160'sd1 <<< (DW-1)) - 1;
      minv = -(160'sd1 <<< (DW-1));
      if (v > maxv) begin
         ov = 1'b1;
         return maxv[DW-1:0];
      end
      if (v < minv) begin
         ov = 1'b1;
         return minv[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   function automatic logic signed [159:0] quotient_part(input logic signed [159:0] num,
                                                         input logic signed [159:0] den);
      logic signed [159:0] mag;
      logic signed [159:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< FB) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic alu_result complex_alu_result(input func_type fn,
         input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
         input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi,
         input logic [THR_W-1:0] thr);
      alu_result r;
      logic signed [159:0] re;
      logic signed [159:0] im;
      logic signed [159:0] den;
      logic signed [159:0] half;
      logic signed [159:0] mbr;
      logic signed [159:0] mbi;
      logic ov;
      logic dz;
      logic eq;
      re = 0;
      im = 0;
      ov = 0;
      dz = 0;
      eq = 0;
      half = 160'sd1 <<< (FB-1);
      case (fn)
         FN_ADD: begin
            re = 160'(ar) + 160'(br);
            im = 160'(ai) + 160'(bi);
         end
         FN_SUB: begin
            re = 160'(ar) - 160'(br);
            im = 160'(ai) - 160'(bi);
         end
         FN_MUL: begin
            re = (160'(ar)*160'(br) - 160'(ai)*160'(bi) + half) >>> FB;
            im = (160'(ai)*160'(br) + 160'(ar)*160'(bi) + half) >>> FB;
         end
         FN_DIV: begin
            den = 160'(br)*160'(br) + 160'(bi)*160'(bi);
            mbr = (br < 0) ? -160'(br) : 160'(br);
            mbi = (bi < 0) ? -160'(bi) : 160'(bi);
            if ((mbr < 160'(thr) && mbi < 160'(thr)) || den == 0) begin
               dz = 1;
            end else begin
               re = quotient_part(160'(ar)*160'(br) + 160'(ai)*160'(bi), den);
               im = quotient_part(160'(ai)*160'(br) - 160'(ar)*160'(bi), den);
            end
         end
         FN_CONJ: begin
            re = 160'(ar);
            im = -160'(ai);
         end
         FN_NEG: begin
            re = -160'(ar);
            im = -160'(ai);
         end
         FN_CMP: eq = (ar == br) && (ai == bi);
         default: ;
      endcase
      r.res_re = clamp_part(re, ov);
      r.res_im = clamp_part(im, ov);
      r.div_zero = dz;
      r.overflow = ov;
      r.equal = eq;
      return r;
   endfunction

   class result_scoreboard;
      alu_result pending[$];
      int mismatches;
      int checked;

      function void note_request(func_type fn, logic [DW-1:0] ar, logic [DW-1:0] ai,
                                 logic [DW-1:0] br, logic [DW-1:0] bi, logic [THR_W-1:0] thr);
         pending.push_back(complex_alu_result(fn, ar, ai, br, bi, thr));
      endfunction

      function void check_result(logic [RSP_W-1:0] data);
         alu_result got;
         alu_result want;
         got.res_re = data[DW-1:0];
         got.res_im = data[2*DW-1:DW];
         got.div_zero = data[2*DW];
         got.overflow = data[2*DW+1];
         got.equal = data[2*DW+2];
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h", data);
            return;
         end
         want = pending.pop_front();
         if (got !== want || data[RSP_W-1:2*DW+3] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected re=%h im=%h dz=%b ov=%b eq=%b, ",
                         "got re=%h im=%h dz=%b ov=%b eq=%b"},
                        want.res_re, want.res_im, want.div_zero, want.overflow, want.equal,
                        got.res_re, got.res_im, got.div_zero, got.overflow, got.equal);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [0:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   complex_arith_unit dut (.*);

   always #6 clock = ~clock;

   result_scoreboard board = new();
   logic [THR_W-1:0] threshold = THR_RESET;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles = 0;
   int sent = 0;
   int div_zero_seen = 0;
   int overflow_seen = 0;

   // receiver side: random stalls, checks each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata);
            div_zero_seen += rsp_tdata[2*DW];
            overflow_seen += rsp_tdata[2*DW+1];
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", board.pending.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send_item(func_type fn, logic [DW-1:0] ar, logic [DW-1:0] ai,
                            logic [DW-1:0] br, logic [DW-1:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_W'({bi, br, ai, ar, fn});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(fn, ar, ai, br, bi, threshold);
      sent++;
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_THR;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      threshold = value;
      @(posedge clock);
   endtask

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(9))
         0: return {1'b1, {(DW-1){1'b0}}};
         1: return {1'b0, {(DW-1){1'b1}}};
         2: return DW'($urandom_range(3)) - 1;
         3: return DW'(signed'($urandom_range(65535)) - 32768);
         4: return DW'(signed'($urandom_range(20)) - 10) <<< FB;
         5: return DW'($urandom_range(1 << 20)) - DW'(1 << 19);
         default: return DW'($urandom());
      endcase
   endfunction

   task automatic random_items(int count);
      func_type fn;
      logic [DW-1:0] ar;
      logic [DW-1:0] ai;
      logic [DW-1:0] br;
      logic [DW-1:0] bi;
      for (int i = 0; i < count; i++) begin
         fn = func_type'($urandom_range(6));
         ar = pick_value();
         ai = pick_value();
         br = pick_value();
         bi = pick_value();
         case ($urandom_range(7))
            0: begin
               br = ar;
               bi = ai;
            end
            1: bi = 0;
            2: begin
               br = DW'(signed'($urandom_range(2*threshold + 2)) - int'(threshold) - 1);
               bi = DW'(signed'($urandom_range(2*threshold + 2)) - int'(threshold) - 1);
            end
            default: ;
         endcase
         send_item(fn, ar, ai, br, bi);
      end
   endtask

   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] ONE = DW'(1) << FB;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every code, zero divisor and saturation cases
      send_item(FN_ADD, MAXV, MINV, MAXV, MINV);
      send_item(FN_ADD, ONE, '1, ONE, 1);
      send_item(FN_SUB, MINV, MAXV, MAXV, MINV);
      send_item(FN_SUB, ONE, ONE, 0, '1);
      send_item(FN_MUL, MAXV, MAXV, MAXV, MINV);
      send_item(FN_MUL, MINV, MINV, MINV, MINV);
      send_item(FN_MUL, ONE, '1, 3 << FB, 2 << FB);
      send_item(FN_MUL, 32'h8000, 0, 1, 0);
      send_item(FN_DIV, ONE, ONE, 0, 0);
      send_item(FN_DIV, ONE, ONE, 1, 0);
      send_item(FN_DIV, MAXV, MINV, 1, 1);
      send_item(FN_DIV, 3 << FB, ONE, ONE, '1);
      send_item(FN_DIV, MINV, MAXV, MINV, MINV);
      send_item(FN_CONJ, MINV, MINV, 0, 0);
      send_item(FN_CONJ, MAXV, ONE, 0, 0);
      send_item(FN_NEG, MINV, MAXV, 0, 0);
      send_item(FN_NEG, '1, 0, 0, 0);
      send_item(FN_CMP, MAXV, MINV, MAXV, MINV);
      send_item(FN_CMP, MAXV, MINV, MAXV, MAXV);
      send_item(FN_CMP, 5, 6, 6, 5);
      send_item(func_type'(7), MAXV, MAXV, ONE, ONE);
      drain();

      write_threshold(0);
      send_item(FN_DIV, ONE, ONE, 0, 0);
      send_item(FN_DIV, ONE, '1, 1, 0);
      drain();
      write_threshold('1);
      send_item(FN_DIV, ONE, ONE, 16'hfffe, 32'hffff0002);
      send_item(FN_DIV, ONE, ONE, 32'h10000, 0);
      drain();

      send_idle_pct = 32;
      recv_idle_pct = 57;
      write_threshold(THR_RESET);
      random_items(260);
      drain();
      write_threshold(16'd300);
      random_items(90);
      drain();

      send_idle_pct = 57;
      recv_idle_pct = 32;
      write_threshold(0);
      random_items(170);
      drain();
      write_threshold('1);
      random_items(180);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold(16'd40);
      random_items(325);
      drain();

      $display("sent %0d items, checked %0d results (%0d zero-divisor, %0d saturated)",
               sent, board.checked, div_zero_seen, overflow_seen);
      $display("threshold swept over 0, 1, 40, 300 and 65535 under three stall mixes");
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
